[hw/rtl/smh_pkg.sv]
// ----------------------------------------------------------------------------
// smh_pkg: shared types and constants of the sequence mix hash
// Hash constants, shift amounts and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package smh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = WordW / 2;

  localparam logic [WordW-1:0] HashInit = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] HashBias = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] FinMulA  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] FinMulB  = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned ShiftPre  = 30;
  localparam int unsigned ShiftMid  = 27;
  localparam int unsigned ShiftPost = 31;
  localparam int unsigned CombShl   = 6;
  localparam int unsigned CombShr   = 2;

  // One command per cycle from the controller; several may not be combined
  // except hash_init with hash_wr and out_wr, and mul_b, which goes with all.
  typedef struct packed {
    logic load_sum;   // Combine the accepted word into a new operand.
    logic mul_lo;     // Low by low partial product into the accumulator.
    logic mul_x1;     // Add low half of a_lo * k_hi into the upper half.
    logic mul_x2;     // Add low half of a_hi * k_lo into the upper half.
    logic mul_b;      // Select the second finalizer constant.
    logic mix;        // Middle xor-shift of the finalizer.
    logic fold_xor;   // End of first finalizer: xor into hash, start second.
    logic hash_wr;    // End of second finalizer: write the running hash.
    logic hash_init;  // Return the running hash to its initial value.
    logic out_wr;     // Load the result register.
  } smh_cmd_t;

  function automatic logic [WordW-1:0] xorshr(input logic [WordW-1:0] v,
                                              input int unsigned sh);
    xorshr = v ^ (v >> sh);
  endfunction

endpackage

[hw/rtl/smh_ctrl.sv]
// ----------------------------------------------------------------------------
// smh_ctrl: controller of the sequence mix hash
// Sequences the two finalizer passes over the shared multiplier and owns
// the handshakes of both channels.
// ----------------------------------------------------------------------------
module smh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              end_of_run_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smh_pkg::smh_cmd_t cmd_o
);
  import smh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MLO  = 6'b000010,
    S_MX1  = 6'b000100,
    S_MX2  = 6'b001000,
    S_MIX  = 6'b010000,
    S_FOLD = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;      // 0: first finalizer, 1: second
  logic   kb_q, kb_d;          // 0: first constant, 1: second
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    kb_d        = kb_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_b = kb_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load_sum = 1'b1;
          last_d         = end_of_run_i;
          pass_d         = 1'b0;
          kb_d           = 1'b0;
          state_d        = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MX1;
      end
      S_MX1: begin
        cmd_o.mul_x1 = 1'b1;
        state_d      = S_MX2;
      end
      S_MX2: begin
        cmd_o.mul_x2 = 1'b1;
        state_d      = kb_q ? S_FOLD : S_MIX;
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        kb_d      = 1'b1;
        state_d   = S_MLO;
      end
      S_FOLD: begin
        if (!pass_q) begin
          cmd_o.fold_xor = 1'b1;
          pass_d         = 1'b1;
          kb_d           = 1'b0;
          state_d        = S_MLO;
        end else if (!last_q) begin
          cmd_o.hash_wr = 1'b1;
          state_d       = S_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // The previous result has left or leaves now, so the result register is free.
          cmd_o.hash_wr   = 1'b1;
          cmd_o.hash_init = 1'b1;
          cmd_o.out_wr    = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      kb_q        <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      kb_q        <= kb_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/smh_datapath.sv]
// ----------------------------------------------------------------------------
// smh_datapath: datapath of the sequence mix hash
// Running hash, operand and accumulator registers around one 32x32
// multiplier that builds each 64-bit product in three steps.
// ----------------------------------------------------------------------------
module smh_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  smh_pkg::smh_cmd_t          cmd_i,
  input  logic [smh_pkg::WordW-1:0]  word_value_i,
  output logic [smh_pkg::WordW-1:0]  hash_value_o
);
  import smh_pkg::*;

  logic [WordW-1:0] hash_q, hash_d;
  logic [WordW-1:0] a_q, a_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [WordW-1:0] out_q;
  logic [WordW-1:0] sum, fin, folded, kconst;
  logic [HalfW-1:0] mul_a, mul_k;
  logic [WordW-1:0] prod;

  assign sum    = word_value_i + HashBias + (hash_q << CombShl) + (hash_q >> CombShr);
  assign fin    = xorshr(acc_q, ShiftPost);
  assign folded = hash_q ^ fin;
  assign kconst = cmd_i.mul_b ? FinMulB : FinMulA;

  // Only the low 64 bits of the product are kept, so the high by high term
  // drops out and each cross term contributes its low half alone.
  assign mul_a = cmd_i.mul_x2 ? a_q[WordW-1:HalfW] : a_q[HalfW-1:0];
  assign mul_k = cmd_i.mul_x1 ? kconst[WordW-1:HalfW] : kconst[HalfW-1:0];
  assign prod  = WordW'(mul_a) * WordW'(mul_k);

  always_comb begin
    a_d    = a_q;
    acc_d  = acc_q;
    hash_d = hash_q;
    if (cmd_i.load_sum) begin
      a_d = xorshr(sum, ShiftPre);
    end
    if (cmd_i.mix) begin
      a_d = xorshr(acc_q, ShiftMid);
    end
    if (cmd_i.fold_xor) begin
      hash_d = folded;
      a_d    = xorshr(folded, ShiftPre);
    end
    if (cmd_i.mul_lo) begin
      acc_d = prod;
    end
    if (cmd_i.mul_x1 || cmd_i.mul_x2) begin
      acc_d[WordW-1:HalfW] = acc_q[WordW-1:HalfW] + prod[HalfW-1:0];
    end
    if (cmd_i.hash_wr) begin
      hash_d = cmd_i.hash_init ? HashInit : fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    acc_q <= acc_d;
    if (cmd_i.out_wr) begin
      out_q <= fin;
    end
  end

  assign hash_value_o = out_q;

endmodule

[hw/rtl/sequence_mix_hash64.sv]
// ----------------------------------------------------------------------------
// sequence_mix_hash64: streaming 64-bit hash over a run of words
// Folds each word into a running hash and emits the hash on the last word.
// ----------------------------------------------------------------------------
// Each accepted word is handled in steps: one to form the combined sum, then
// two finalizer passes of two 64-bit products each, every product built in
// three steps on a single shared 32x32 multiplier, plus one xor-shift step
// after each product. A word is taken only while the block is idle, so a new
// word waits until the last one is through. The hash of a run appears on the
// output for the word marked end_of_run and waits in a result register, so
// the next run can start before it is taken; a marked word stalls at its end
// while an older result still waits. The running hash then restarts from its initial constant.
module sequence_mix_hash64 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [smh_pkg::WordW-1:0] word_value_i,
  input  logic                      end_of_run_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [smh_pkg::WordW-1:0] hash_value_o
);
  import smh_pkg::*;

  smh_cmd_t cmd;

  smh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .end_of_run_i (end_of_run_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  smh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .word_value_i (word_value_i),
    .hash_value_o (hash_value_o)
  );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sequence_mix_hash64
// Streams runs of 64-bit words into the block. A local copy of the folding
// hash predicts the hash for every marked word, and each hash that the block
// emits is compared in order. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned W            = smh_pkg::WordW;
  localparam int unsigned WordTarget   = 1800;
  localparam int unsigned CalmTail     = 250;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned WatchdogMax  = 2000;

  typedef struct {
    logic [W-1:0] word;
    logic         last;
    bit           wait_drain;
  } word_item_t;

  logic         clk_i        = 1'b0;
  logic         rst_ni       = 1'b0;
  logic         in_valid_i   = 1'b0;
  logic         in_ready_o;
  logic [W-1:0] word_value_i = '0;
  logic         end_of_run_i = 1'b0;
  logic         out_valid_o;
  logic         out_ready_i  = 1'b0;
  logic [W-1:0] hash_value_o;

  word_item_t   pending_words[$];
  logic [W-1:0] expected_hashes[$];
  logic [W-1:0] hash_state     = smh_pkg::HashInit;
  logic         word_taken     = 1'b0;
  int unsigned  accepted_words = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  send_gap       = 0;
  int unsigned  recv_stall     = 0;
  bit           stim_loaded    = 1'b0;

  sequence_mix_hash64 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_value_i (word_value_i),
    .end_of_run_i (end_of_run_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  always #2 clk_i = ~clk_i;

  // splitmix64 finalizer, all products wrapping at 64 bits.
  function automatic logic [W-1:0] splitmix_finish(input logic [W-1:0] v);
    logic [W-1:0] t;
    t = v ^ (v >> smh_pkg::ShiftPre);
    t = t * smh_pkg::FinMulA;
    t = t ^ (t >> smh_pkg::ShiftMid);
    t = t * smh_pkg::FinMulB;
    return t ^ (t >> smh_pkg::ShiftPost);
  endfunction

  function automatic logic [W-1:0] fold_word(input logic [W-1:0] h, input logic [W-1:0] w);
    logic [W-1:0] sum;
    logic [W-1:0] mixed;
    sum   = w + smh_pkg::HashBias + (h << smh_pkg::CombShl) + (h >> smh_pkg::CombShr);
    mixed = h ^ splitmix_finish(sum);
    return splitmix_finish(mixed);
  endfunction

  // Odds of starting an idle burst: 0 means none. The mode rotates with the
  // number of accepted words, and the tail of the run is kept free of idling.
  function automatic int unsigned idle_odds();
    if (stim_loaded && pending_words.size() < CalmTail) return 0;
    case ((accepted_words / 150) % 3)
      0:       return 0;
      1:       return 12;
      default: return 3;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] want,
                                 input logic [W-1:0] got);
    mismatch_count++;
    $display("MISMATCH %s: expected %h, got %h at %0t ns", what, want, got, $time);
  endtask

  task automatic add_word(input logic [W-1:0] w, input logic last, input bit drain);
    word_item_t it;
    it.word       = w;
    it.last       = last;
    it.wait_drain = drain;
    pending_words.insert(pending_words.size(), it);
  endtask

  function automatic logic [W-1:0] random_word();
    case ($urandom_range(0, 3))
      0:       return {$urandom, $urandom};
      1:       return W'($urandom_range(0, 255));
      2:       return W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return {1'b1, {(W-1){1'b0}}};
          default: return W'(1);
        endcase
      end
    endcase
  endfunction

  // Sender: a new item is presented only when the previous one was taken.
  always @(negedge clk_i) begin
    word_item_t  it;
    int unsigned odds;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      odds = idle_odds();
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].wait_drain && expected_hashes.size() != 0)) begin
        in_valid_i <= 1'b0;
      end else if (odds != 0 && $urandom_range(1, odds) == 1) begin
        send_gap = $urandom_range(0, 6);
        in_valid_i <= 1'b0;
      end else begin
        it = pending_words.pop_front();
        in_valid_i   <= 1'b1;
        word_value_i <= it.word;
        end_of_run_i <= it.last;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    int unsigned odds;
    odds = idle_odds();
    if (recv_stall != 0) begin
      recv_stall = recv_stall - 1;
      out_ready_i <= 1'b0;
    end else if (odds != 0 && $urandom_range(1, odds) == 1) begin
      recv_stall = $urandom_range(0, 6);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: update the predicted hash on each accepted word and check each
  // emitted hash against the oldest prediction.
  always @(posedge clk_i) begin
    logic in_fire;
    logic out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    word_taken <= in_fire;
    if (in_fire) begin
      hash_state = fold_word(hash_state, word_value_i);
      accepted_words++;
      if (end_of_run_i) begin
        expected_hashes.insert(expected_hashes.size(), hash_state);
        hash_state = smh_pkg::HashInit;
      end
    end
    if (out_fire) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch("hash with none pending", '0, hash_value_o);
      end else if (hash_value_o !== expected_hashes[0]) begin
        report_mismatch("hash_value", expected_hashes[0], hash_value_o);
        void'(expected_hashes.pop_front());
      end else begin
        void'(expected_hashes.pop_front());
      end
    end
    if (in_fire || out_fire) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogMax) begin
        $display("watchdog: no item moved for %0d cycles", WatchdogMax);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int unsigned names;
    int unsigned count;
    int unsigned runs;
    bit          first_random;

    // Single-word runs at the extremes.
    add_word('0, 1'b1, 1'b0);
    add_word('1, 1'b1, 1'b0);
    add_word({1'b1, {(W-1){1'b0}}}, 1'b1, 1'b0);
    add_word(W'(1), 1'b1, 1'b0);
    // Unmarked words that only update the hash, then the mark.
    add_word('0, 1'b0, 1'b0);
    add_word('0, 1'b0, 1'b0);
    add_word('0, 1'b1, 1'b0);
    add_word('1, 1'b0, 1'b0);
    add_word('1, 1'b1, 1'b0);
    add_word(W'(8), 1'b0, 1'b0);
    add_word(W'(255), 1'b1, 1'b0);
    // A well-formed record: two name bytes, root, count, two offsets.
    add_word(W'(8'h61), 1'b0, 1'b0);
    add_word(W'(8'h62), 1'b0, 1'b0);
    add_word('0, 1'b0, 1'b0);
    add_word(W'(2), 1'b0, 1'b0);
    add_word(W'(32'hFFFF_FFFF), 1'b0, 1'b0);
    add_word('0, 1'b1, 1'b0);

    first_random = 1'b1;
    runs = 0;
    while (pending_words.size() < WordTarget) begin
      runs++;
      if ($urandom_range(0, 3) != 0) begin
        // Well-formed record with random content.
        names = $urandom_range(0, 6);
        count = $urandom_range(0, 5);
        add_word(W'($urandom_range(0, 255)), 1'b0,
                 first_random || $urandom_range(0, 59) == 0);
        for (int unsigned i = 1; i < names; i++)
          add_word(W'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_word(W'($urandom), 1'b0, 1'b0);
        add_word(W'(count), count == 0, 1'b0);
        for (int unsigned i = 0; i < count; i++)
          add_word(W'($urandom), i == count - 1, 1'b0);
      end else begin
        // Arbitrary words; now and then a long run.
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < count; i++)
          add_word(random_word(), i == count - 1,
                   i == 0 && (first_random || $urandom_range(0, 59) == 0));
      end
      first_random = 1'b0;
    end
    stim_loaded = 1'b1;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_hashes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (expected_hashes.size() != 0) begin
      report_mismatch("hash never emitted", expected_hashes[0], '0);
      void'(expected_hashes.pop_front());
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
